// File: rtl/core/wia_pkg.sv
// Shared types, operation codes and helpers of the wide integer ALU.
package wia_pkg;

	localparam int WORD_BITS     = 128;
	localparam int HALF_BITS     = 64;
	localparam int QUEUE_DEPTH   = 4;
	localparam int IN_DATA_BITS  = 272;
	localparam int OUT_DATA_BITS = 136;
	localparam int MUL_PAIRS     = 10;

	localparam logic [3:0] ACT_ADD = 4'd0;
	localparam logic [3:0] ACT_SUB = 4'd1;
	localparam logic [3:0] ACT_MUL = 4'd2;
	localparam logic [3:0] ACT_DIV = 4'd3;
	localparam logic [3:0] ACT_MOD = 4'd4;
	localparam logic [3:0] ACT_AND = 4'd5;
	localparam logic [3:0] ACT_OR  = 4'd6;
	localparam logic [3:0] ACT_XOR = 4'd7;
	localparam logic [3:0] ACT_NOT = 4'd8;
	localparam logic [3:0] ACT_NEG = 4'd9;
	localparam logic [3:0] ACT_SHL = 4'd10;
	localparam logic [3:0] ACT_SHR = 4'd11;
	localparam logic [3:0] ACT_ROL = 4'd12;
	localparam logic [3:0] ACT_ROR = 4'd13;

	typedef enum logic [1:0] {
		KIND_SIMPLE = 2'd0,
		KIND_MUL    = 2'd1,
		KIND_DIV    = 2'd2,
		KIND_MOD    = 2'd3
	} wia_kind_t;

	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
		logic dz;
	} wia_flags_t;

	typedef struct packed {
		wia_kind_t             kind;
		logic [WORD_BITS-1:0]  a;
		logic [WORD_BITS-1:0]  b;
		logic [WORD_BITS-1:0]  res;
		wia_flags_t            flags;
	} wia_entry_t;

	// 32-bit limb pairs whose product lands in the low 128 bits: {i, j}
	function automatic logic [3:0] mul_pair(input logic [3:0] idx);
		logic [3:0] p;
		case (idx)
			4'd0:    p = {2'd0, 2'd0};
			4'd1:    p = {2'd0, 2'd1};
			4'd2:    p = {2'd1, 2'd0};
			4'd3:    p = {2'd0, 2'd2};
			4'd4:    p = {2'd1, 2'd1};
			4'd5:    p = {2'd2, 2'd0};
			4'd6:    p = {2'd0, 2'd3};
			4'd7:    p = {2'd1, 2'd2};
			4'd8:    p = {2'd2, 2'd1};
			4'd9:    p = {2'd3, 2'd0};
			default: p = 4'd0;
		endcase
		return p;
	endfunction

endpackage

// File: rtl/core/wide_integer_alu_unit.sv
// Top level of the 128-bit integer ALU.
// Usage: operations enter on the s_axis group (tvalid/tready/tdata), one
// transfer per operation; results leave on the m_axis group, one transfer
// per operation, in order. Operands are 128-bit two's complement, each given
// as a signed upper and an unsigned lower 64-bit half.
// Path: simple operations (add, sub, logic, shifts, rotates and any
// divide by zero) pass the input register, the queue and the output
// register. Multiply computes one 32x32 partial product per cycle in the
// back end; divide takes one restoring-division step per cycle; mod runs
// the divide, multiplies the quotient by B and subtracts it from A.
// Throughput: one simple operation per cycle while the receiver is ready
// and the back end is idle; the back end holds one multiply or divide at a
// time while a 4-entry queue keeps taking operations from the front end.
// Reset clears the queue, both valid registers and the sequencer; any
// operation in flight is dropped, and none is invented across it. When the
// receiver holds m_axis_tready low, the result stays stable and the queue
// fills before s_axis_tready drops.
module wide_integer_alu_unit #(
	parameter int QUEUE_DEPTH = wia_pkg::QUEUE_DEPTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// action[3:0], a_high[67:4], a_low[131:68], b_high[195:132],
	// b_low[259:196], shift_amount[266:260], zero fill
	input  logic [wia_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// result_high[63:0], result_low[127:64], a_less[128], a_equal[129],
	// a_greater[130], divide_by_zero[131], zero fill
	output logic [wia_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata
);

	logic                          push;
	logic                          full;
	logic                          pop;
	logic                          not_empty;
	wia_pkg::wia_entry_t           wr_entry;
	wia_pkg::wia_entry_t           rd_entry;
	logic [wia_pkg::WORD_BITS-1:0] res;
	wia_pkg::wia_flags_t           flags;

	wia_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.action       (s_axis_tdata[3:0]),
		.op_a         ({s_axis_tdata[67:4], s_axis_tdata[131:68]}),
		.op_b         ({s_axis_tdata[195:132], s_axis_tdata[259:196]}),
		.shift_amount (s_axis_tdata[266:260]),
		.push         (push),
		.full         (full),
		.entry        (wr_entry)
	);

	wia_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.rd_entry  (rd_entry)
	);

	wia_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (not_empty),
		.entry     (rd_entry),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res),
		.out_flags (flags)
	);

	assign m_axis_tdata = {4'd0, flags.dz, flags.gt, flags.eq, flags.lt,
		res[63:0], res[127:64]};

endmodule

// File: rtl/core/wia_front.sv
// Front end: input register, classification and simple operations.
module wia_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [3:0]                          action,
	input  logic [wia_pkg::WORD_BITS-1:0]       op_a,
	input  logic [wia_pkg::WORD_BITS-1:0]       op_b,
	input  logic [6:0]                          shift_amount,
	output logic                                push,
	input  logic                                full,
	output wia_pkg::wia_entry_t                 entry
);

	logic                            v_s1;
	logic [3:0]                      act_s1;
	logic [wia_pkg::WORD_BITS-1:0]   a_s1;
	logic [wia_pkg::WORD_BITS-1:0]   b_s1;
	logic [6:0]                      n_s1;
	logic [2*wia_pkg::WORD_BITS-1:0] rol_w;
	logic [2*wia_pkg::WORD_BITS-1:0] ror_w;
	logic                            b_zero;

	assign in_ready = !v_s1 || !full;
	assign push     = v_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			act_s1 <= action;
			a_s1   <= op_a;
			b_s1   <= op_b;
			n_s1   <= shift_amount;
		end
	end

	assign rol_w  = {a_s1, a_s1} << n_s1;
	assign ror_w  = {a_s1, a_s1} >> n_s1;
	assign b_zero = (b_s1 == '0);

	always_comb begin
		entry          = '0;
		entry.kind     = wia_pkg::KIND_SIMPLE;
		entry.a        = a_s1;
		entry.b        = b_s1;
		entry.flags.eq = (a_s1 == b_s1);
		entry.flags.lt = ($signed(a_s1) < $signed(b_s1));
		entry.flags.gt = !entry.flags.eq && !entry.flags.lt;
		case (act_s1)
			wia_pkg::ACT_ADD: entry.res = a_s1 + b_s1;
			wia_pkg::ACT_SUB: entry.res = a_s1 - b_s1;
			wia_pkg::ACT_MUL: entry.kind = wia_pkg::KIND_MUL;
			wia_pkg::ACT_DIV: begin
				entry.flags.dz = b_zero;
				if (!b_zero) entry.kind = wia_pkg::KIND_DIV;
			end
			wia_pkg::ACT_MOD: begin
				entry.flags.dz = b_zero;
				if (b_zero) entry.res = a_s1;
				else entry.kind = wia_pkg::KIND_MOD;
			end
			wia_pkg::ACT_AND: entry.res = a_s1 & b_s1;
			wia_pkg::ACT_OR:  entry.res = a_s1 | b_s1;
			wia_pkg::ACT_XOR: entry.res = a_s1 ^ b_s1;
			wia_pkg::ACT_NOT: entry.res = ~a_s1;
			wia_pkg::ACT_NEG: entry.res = -a_s1;
			wia_pkg::ACT_SHL: entry.res = a_s1 << n_s1;
			wia_pkg::ACT_SHR: entry.res = a_s1 >> n_s1;
			wia_pkg::ACT_ROL: entry.res = rol_w[2*wia_pkg::WORD_BITS-1:wia_pkg::WORD_BITS];
			wia_pkg::ACT_ROR: entry.res = ror_w[wia_pkg::WORD_BITS-1:0];
			default:          entry.res = '0;
		endcase
	end

endmodule

// File: rtl/core/wia_queue.sv
// Short queue between front and back end.
module wia_queue #(
	parameter int DEPTH = wia_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  wia_pkg::wia_entry_t wr_entry,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output wia_pkg::wia_entry_t rd_entry
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	wia_pkg::wia_entry_t slots_q [DEPTH];
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [CW-1:0]       count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_entry  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= wr_entry;
	end

endmodule

// File: rtl/core/wia_back.sv
// Back end: multi-cycle multiply and divide, plus the output register.
module wia_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                avail,
	input  wia_pkg::wia_entry_t                 entry,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [wia_pkg::WORD_BITS-1:0]       out_res,
	output wia_pkg::wia_flags_t                 out_flags
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_DFIX = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_FIN  = 5'b10000
	} wia_state_t;

	wia_state_t                    state_q;
	logic [6:0]                    cnt_q;
	logic                          is_mod_q;
	logic [wia_pkg::WORD_BITS-1:0] a_keep_q;
	wia_pkg::wia_flags_t           flags_q;
	logic [wia_pkg::WORD_BITS-1:0] mx_q;
	logic [wia_pkg::WORD_BITS-1:0] my_q;
	logic [63:0]                   prod_q;
	logic [1:0]                    k_q;
	logic [wia_pkg::WORD_BITS-1:0] acc_q;
	logic [wia_pkg::WORD_BITS-1:0] rem_q;
	logic [wia_pkg::WORD_BITS-1:0] quo_q;
	logic [wia_pkg::WORD_BITS-1:0] dvs_q;
	logic                          neg_q;
	logic                          out_valid_q;

	logic                          out_free;
	logic                          load_out;
	logic [3:0]                    pair;
	logic [wia_pkg::WORD_BITS:0]   sh;
	logic [wia_pkg::WORD_BITS+1:0] diff;
	logic [wia_pkg::WORD_BITS-1:0] a_abs;
	logic [wia_pkg::WORD_BITS-1:0] b_abs;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign pop = (state_q == ST_IDLE) && avail &&
		(entry.kind != wia_pkg::KIND_SIMPLE || out_free);
	assign load_out = (pop && entry.kind == wia_pkg::KIND_SIMPLE) ||
		(state_q == ST_FIN && out_free);

	assign pair  = wia_pkg::mul_pair(cnt_q[3:0]);
	assign sh    = {rem_q, quo_q[wia_pkg::WORD_BITS-1]};
	assign diff  = {1'b0, sh} - {2'b00, dvs_q};
	assign a_abs = entry.a[wia_pkg::WORD_BITS-1] ? -entry.a : entry.a;
	assign b_abs = entry.b[wia_pkg::WORD_BITS-1] ? -entry.b : entry.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (pop && entry.kind != wia_pkg::KIND_SIMPLE)
						state_q <= (entry.kind == wia_pkg::KIND_MUL) ? ST_MUL : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'(wia_pkg::WORD_BITS - 1)) state_q <= ST_DFIX;
				end
				ST_DFIX: begin
					cnt_q   <= '0;
					state_q <= is_mod_q ? ST_MUL : ST_FIN;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'(wia_pkg::MUL_PAIRS)) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					flags_q  <= entry.flags;
					a_keep_q <= entry.a;
					is_mod_q <= (entry.kind == wia_pkg::KIND_MOD);
					mx_q     <= entry.a;
					my_q     <= entry.b;
					acc_q    <= '0;
					rem_q    <= '0;
					quo_q    <= a_abs;
					dvs_q    <= b_abs;
					neg_q    <= entry.a[wia_pkg::WORD_BITS-1] ^ entry.b[wia_pkg::WORD_BITS-1];
					// output register only moves when a result is loaded
					if (entry.kind == wia_pkg::KIND_SIMPLE) begin
						out_res   <= entry.res;
						out_flags <= entry.flags;
					end
				end
			end
			ST_DIV: begin
				// restoring step: shift in next dividend bit, subtract if it fits
				if (!diff[wia_pkg::WORD_BITS+1]) begin
					rem_q <= diff[wia_pkg::WORD_BITS-1:0];
					quo_q <= {quo_q[wia_pkg::WORD_BITS-2:0], 1'b1};
				end else begin
					rem_q <= sh[wia_pkg::WORD_BITS-1:0];
					quo_q <= {quo_q[wia_pkg::WORD_BITS-2:0], 1'b0};
				end
			end
			ST_DFIX: begin
				mx_q  <= neg_q ? -quo_q : quo_q;
				acc_q <= is_mod_q ? '0 : (neg_q ? -quo_q : quo_q);
			end
			ST_MUL: begin
				if (cnt_q < 7'(wia_pkg::MUL_PAIRS)) begin
					prod_q <= 64'(mx_q[pair[3:2]*32 +: 32]) * 64'(my_q[pair[1:0]*32 +: 32]);
					k_q    <= pair[3:2] + pair[1:0];
				end
				if (cnt_q != '0) acc_q <= acc_q + ({64'd0, prod_q} << (k_q * 32));
			end
			ST_FIN: begin
				if (out_free) begin
					out_res   <= is_mod_q ? a_keep_q - acc_q : acc_q;
					out_flags <= flags_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/core/wia_checker.sv
// Port-level checks of the wide integer ALU, bound to the top level.
module wia_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [wia_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

	// exactly one compare flag per result
	a_flags_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot(m_axis_tdata[130:128]))
		else $error("compare flags not one-hot");

	// zero over zero: div gives 0, mod gives A which is 0
	a_zero_by_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[131] && m_axis_tdata[129])
		|-> (m_axis_tdata[127:0] == '0))
		else $error("zero by zero gave non-zero result");

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_data_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

endmodule

bind wide_integer_alu_unit wia_checker u_chk (.*);
